// File: sv/spb_pkg.sv
// Shared types, constants and saturation helper for the swept particle bounds block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none
package spb_pkg;

	// divider: one quotient bit per stage; turning travel fits in 48 bits
	localparam int DIV_STAGES = 48;
	localparam int DIV_REM_W  = 34;
	// lane s1..s4, divider stages, lane result stage, merge output stage
	localparam int PIPE_LAT   = DIV_STAGES + 6;
	// radius is ready after two stages and waits for the lanes
	localparam int RAD_DLY    = PIPE_LAT - 3;

	// floor(x/100) = (x * RECIP_100) >> RECIP_SHIFT for x < 2^31
	localparam logic [31:0] RECIP_100   = 32'd2748779070;
	localparam int          RECIP_SHIFT = 38;

	typedef struct packed {
		logic signed [31:0] p;
		logic signed [31:0] v;
		logic signed [31:0] a;
		logic        [30:0] t;
	} lane_in_t;

	// travels with the divider
	typedef struct packed {
		logic signed [63:0] d;
		logic signed [31:0] p;
		logic signed [31:0] ve;
		logic               use_c;
		logic               vneg;
	} side_t;

	typedef struct packed {
		logic signed [63:0] lo_ext;
		logic signed [63:0] hi_ext;
		logic signed [31:0] p;
		logic signed [31:0] pe;
		logic signed [31:0] ve;
	} lane_out_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
		logic signed [31:0] r;
		if (x > 66'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (x < -66'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// File: sv/swept_particle_bounds.sv
// Swept bounds of a circular particle under constant acceleration, two axis lanes.
// Throughput: one word per cycle while the output holds no word or m_axis_tready is high;
// a stalled output freezes the whole pipe. The 48-stage pipelined divider for the
// turning travel sets the latency, and every enabled stage takes a new word each cycle.
// Reset: arst_n clears only the stage valid bits; the datapath is not reset.
`timescale 1ns / 1ps
`default_nettype none
module swept_particle_bounds import spb_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// pos_x[31:0], pos_y[63:32], vel_x[95:64], vel_y[127:96], accel_x[159:128],
	// accel_y[191:160], radius_in[222:192], span[253:223], zero pad [255:254]
	input  wire logic [255:0] s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// box_left[31:0], box_right[63:32], box_top[95:64], box_bottom[127:96],
	// end_pos_x[159:128], end_pos_y[191:160], end_vel_x[223:192], end_vel_y[255:224]
	output logic [255:0]      m_axis_tdata
);

	// whole pipe moves together; the last stage is the output register
	logic                en;
	logic [PIPE_LAT-1:0] vld_q;

	assign en            = !vld_q[PIPE_LAT-1] || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_q[PIPE_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_LAT-2:0], s_axis_tvalid};
		end
	end

	lane_in_t  in_x, in_y;
	lane_out_t out_x, out_y;

	always_comb begin
		in_x.p = s_axis_tdata[31:0];
		in_x.v = s_axis_tdata[95:64];
		in_x.a = s_axis_tdata[159:128];
		in_x.t = s_axis_tdata[253:223];
		in_y.p = s_axis_tdata[63:32];
		in_y.v = s_axis_tdata[127:96];
		in_y.a = s_axis_tdata[191:160];
		in_y.t = s_axis_tdata[253:223];
	end

	spb_axis_lane u_lane_x (
		.clk  (clk),
		.en   (en),
		.din  (in_x),
		.dout (out_x)
	);

	spb_axis_lane u_lane_y (
		.clk  (clk),
		.en   (en),
		.din  (in_y),
		.dout (out_y)
	);

	// radius growth and final add/saturate of both lanes
	spb_merge u_merge (
		.clk       (clk),
		.en        (en),
		.radius_in (s_axis_tdata[222:192]),
		.lane_x    (out_x),
		.lane_y    (out_y),
		.res_q     (m_axis_tdata)
	);

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> vld_q[0])
		else $error("accepted word did not enter the pipe");

	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipe moved while stalled");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
		else $error("input taken while output stalled");

endmodule
`default_nettype wire

// File: sv/spb_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on spb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module spb_div_pipe import spb_pkg::*; (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [63:0] num,
	input  wire logic [32:0] den,
	input  wire side_t       side_in,
	output logic [DIV_STAGES-1:0] quo,
	output side_t            side_out
);

	logic [DIV_REM_W-1:0]  rem_s  [DIV_STAGES];
	logic [DIV_STAGES-1:0] num_s  [DIV_STAGES];
	logic [DIV_STAGES-1:0] quo_s  [DIV_STAGES];
	logic [32:0]           den_s  [DIV_STAGES];
	side_t                 side_s [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic [DIV_REM_W-1:0]  rem_p;
		logic [DIV_STAGES-1:0] num_p;
		logic [DIV_STAGES-1:0] quo_p;
		logic [32:0]           den_p;
		side_t                 side_p;
		logic [DIV_REM_W:0]    trial;
		logic                  ge;

		if (k == 0) begin : g_first
			assign rem_p  = DIV_REM_W'(num[63:DIV_STAGES]);
			assign num_p  = num[DIV_STAGES-1:0];
			assign quo_p  = '0;
			assign den_p  = den;
			assign side_p = side_in;
		end else begin : g_next
			assign rem_p  = rem_s[k-1];
			assign num_p  = num_s[k-1];
			assign quo_p  = quo_s[k-1];
			assign den_p  = den_s[k-1];
			assign side_p = side_s[k-1];
		end

		always_comb begin
			trial = {rem_p, num_p[DIV_STAGES-1]};
			ge    = trial >= (DIV_REM_W+1)'(den_p);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? DIV_REM_W'(trial - (DIV_REM_W+1)'(den_p))
				                : DIV_REM_W'(trial);
				num_s[k]  <= {num_p[DIV_STAGES-2:0], 1'b0};
				quo_s[k]  <= {quo_p[DIV_STAGES-2:0], ge};
				den_s[k]  <= den_p;
				side_s[k] <= side_p;
			end
		end
	end

	assign quo      = quo_s[DIV_STAGES-1];
	assign side_out = side_s[DIV_STAGES-1];

endmodule
`default_nettype wire

// File: sv/spb_axis_lane.sv
// One axis lane: end velocity, travel, turning travel and travel extents.
// Depends on spb_pkg and spb_div_pipe.
`timescale 1ns / 1ps
`default_nettype none
module spb_axis_lane import spb_pkg::*; (
	input  wire logic     clk,
	input  wire logic     en,
	input  wire lane_in_t din,
	output lane_out_t     dout
);

	// s1: products
	logic signed [63:0] at_s1;
	logic        [63:0] vsq_s1, amt_s1;
	logic        [31:0] vm_s1, am_s1;
	logic signed [31:0] p_s1, v_s1;
	logic        [30:0] t_s1;
	logic               anz_s1, opp_s1, vneg_s1;
	logic        [31:0] vm_c, am_c;

	always_comb begin
		vm_c = din.v[31] ? (~din.v + 32'd1) : din.v;
		am_c = din.a[31] ? (~din.a + 32'd1) : din.a;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			at_s1   <= din.a * $signed({1'b0, din.t});
			vsq_s1  <= vm_c * vm_c;
			amt_s1  <= am_c * {1'b0, din.t};
			vm_s1   <= vm_c;
			am_s1   <= am_c;
			p_s1    <= din.p;
			v_s1    <= din.v;
			t_s1    <= din.t;
			anz_s1  <= din.a != '0;
			opp_s1  <= !((din.v > 0 && din.a > 0) || (din.v < 0 && din.a < 0));
			vneg_s1 <= din.v[31];
		end
	end

	// s2: end velocity, half-step velocity, turning test, dividend
	logic signed [47:0] w_s2;
	logic signed [31:0] ve_s2, p_s2;
	logic        [63:0] num_s2;
	logic        [32:0] den_s2;
	logic        [30:0] t_s2;
	logic               use_s2, vneg_s2;
	logic signed [65:0] ve_w;
	logic signed [63:0] w_w;

	always_comb begin
		ve_w = 66'(v_s1) + 66'(at_s1 >>> 16);
		w_w  = 64'(v_s1) + (at_s1 >>> 17);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ve_s2   <= sat32(ve_w);
			w_s2    <= w_w[47:0];
			use_s2  <= anz_s1 && opp_s1 && ({16'b0, vm_s1, 16'b0} <= amt_s1);
			num_s2  <= vsq_s1 + {31'b0, am_s1, 1'b0} - 64'd1;
			den_s2  <= {am_s1, 1'b0};
			p_s2    <= p_s1;
			t_s2    <= t_s1;
			vneg_s2 <= vneg_s1;
		end
	end

	// s3: travel split into high and low partial products
	logic signed [63:0] mh_s3;
	logic        [46:0] ml_s3;
	logic signed [31:0] ve_s3, p_s3;
	logic        [63:0] num_s3;
	logic        [32:0] den_s3;
	logic               use_s3, vneg_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			mh_s3   <= $signed(w_s2[47:16]) * $signed({1'b0, t_s2});
			ml_s3   <= w_s2[15:0] * t_s2;
			ve_s3   <= ve_s2;
			p_s3    <= p_s2;
			num_s3  <= num_s2;
			den_s3  <= den_s2;
			use_s3  <= use_s2;
			vneg_s3 <= vneg_s2;
		end
	end

	// s4: travel d
	side_t       side_s4;
	logic [63:0] num_s4;
	logic [32:0] den_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4.d     <= mh_s3 + $signed({33'b0, ml_s3[46:16]});
			side_s4.p     <= p_s3;
			side_s4.ve    <= ve_s3;
			side_s4.use_c <= use_s3;
			side_s4.vneg  <= vneg_s3;
			num_s4        <= num_s3;
			den_s4        <= den_s3;
		end
	end

	// turning travel magnitude, ceil(v^2 / 2|a|)
	logic [DIV_STAGES-1:0] quo;
	side_t                 side_d;

	spb_div_pipe u_div (
		.clk      (clk),
		.en       (en),
		.num      (num_s4),
		.den      (den_s4),
		.side_in  (side_s4),
		.quo      (quo),
		.side_out (side_d)
	);

	logic signed [63:0] cpos, cval, lo_c, hi_c;
	logic signed [65:0] pe_w;

	always_comb begin
		cpos = $signed(64'(quo));
		cval = side_d.vneg ? -cpos : cpos;
		lo_c = (side_d.d < 0) ? side_d.d : 64'sd0;
		hi_c = (side_d.d > 0) ? side_d.d : 64'sd0;
		if (side_d.use_c && cval < lo_c) begin
			lo_c = cval;
		end
		if (side_d.use_c && cval > hi_c) begin
			hi_c = cval;
		end
		pe_w = 66'(side_d.p) + 66'(side_d.d);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout.lo_ext <= lo_c;
			dout.hi_ext <= hi_c;
			dout.p      <= side_d.p;
			dout.pe     <= sat32(pe_w);
			dout.ve     <= side_d.ve;
		end
	end

endmodule
`default_nettype wire

// File: sv/spb_merge.sv
// Grown radius pipe and merge of both lanes into the saturated result word.
// Depends on spb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module spb_merge import spb_pkg::*; (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [30:0] radius_in,
	input  wire lane_out_t   lane_x,
	input  wire lane_out_t   lane_y,
	output logic [255:0]     res_q
);

	// R = rin + floor(rin / 100)
	logic [63:0] prod_s1;
	logic [30:0] rin_s1;
	logic [31:0] r_s2;
	logic [31:0] r_dly [RAD_DLY];

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= {33'b0, radius_in} * {32'b0, RECIP_100};
			rin_s1  <= radius_in;
			r_s2    <= {1'b0, rin_s1} + 32'(prod_s1 >> RECIP_SHIFT);
			r_dly[0] <= r_s2;
			for (int k = 1; k < RAD_DLY; k++) begin
				r_dly[k] <= r_dly[k-1];
			end
		end
	end

	logic signed [65:0] r_w;
	logic signed [31:0] left_c, right_c, top_c, bottom_c;

	always_comb begin
		r_w      = $signed({34'b0, r_dly[RAD_DLY-1]});
		left_c   = sat32(66'(lane_x.p) + 66'(lane_x.lo_ext) - r_w);
		right_c  = sat32(66'(lane_x.p) + 66'(lane_x.hi_ext) + r_w);
		top_c    = sat32(66'(lane_y.p) + 66'(lane_y.lo_ext) - r_w);
		bottom_c = sat32(66'(lane_y.p) + 66'(lane_y.hi_ext) + r_w);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= {lane_y.ve, lane_x.ve, lane_y.pe, lane_x.pe,
			          bottom_c, top_c, right_c, left_c};
		end
	end

endmodule
`default_nettype wire
